// ===== src/assert_macros.svh =====
// Assertion macros used by the rational arithmetic unit controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property with asynchronous active-low reset disable.
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property checked during reset too.
`define RAU_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAU_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== src/rau_pkg.sv =====
// Types, constants and codes of the rational arithmetic unit.
package rau_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int PORT_WIDTH  = 32;
	localparam int W2          = 2 * VALUE_WIDTH;
	localparam int CNT_W       = $clog2(W2);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_EQ  = 3'd4,
		OP_LT  = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_DIV_ZERO = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SUM,
		S_GCD,
		S_DIV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]                   opcode;
		logic signed [PORT_WIDTH-1:0] a_num;
		logic [PORT_WIDTH-1:0]        a_den;
		logic signed [PORT_WIDTH-1:0] b_num;
		logic [PORT_WIDTH-1:0]        b_den;
	} req_t;

	typedef struct packed {
		logic signed [PORT_WIDTH-1:0] res_num;
		logic [PORT_WIDTH-1:0]        res_den;
		logic                         compare_true;
		logic [1:0]                   status;
	} rsp_t;

	typedef struct packed {
		logic       load_in;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       sum_en;
		logic       gcd_step;
		logic       div_step;
		logic       load_res;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic gcd_done;
	} sts_t;

endpackage

// ===== src/rau_req_if.sv =====
// Operand item channel interface.
interface rau_req_if;
	logic          valid;
	logic          ready;
	rau_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/rau_rsp_if.sv =====
// Result item channel interface.
interface rau_rsp_if;
	logic          valid;
	logic          ready;
	rau_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: controller and datapath.
// Usage:
//   req channel carries opcode and two fractions a_num/a_den, b_num/b_den;
//   rsp channel returns res_num/res_den, compare_true and status.
//   Each item gives exactly one result item; one item is in work at a time.
// Sequence:
//   accept, the cross products and the denominator product on one shared
//   32x32 multiplier, the signed sum, then the binary GCD loop (one step per
//   cycle over the 64-bit values), then exact division by the GCD (two lanes,
//   one quotient bit each per cycle), then the result register.
//   Compares, zero denominators, divide by zero, bad opcodes and zero results
//   skip GCD and division; the GCD loop sets how long arithmetic items take.
// Reset: arst_n clears the controller to idle with no result pending.
// Stall: the result sits in an output register; the next item is accepted
//   and processed, and it waits at completion until the register is taken.
module rational_arithmetic_unit (
	input logic       clk,
	input logic       arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp
);
	rau_pkg::cmd_t cmd;
	rau_pkg::sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rau_datapath u_dp (
		.clk      (clk),
		.req_data (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp.data)
	);
endmodule

// ===== src/rau_datapath.sv =====
// Datapath: cross products, signed sum, binary GCD, exact division, result register.
module rau_datapath (
	input  logic          clk,
	input  rau_pkg::req_t req_data,
	input  rau_pkg::cmd_t cmd,
	output rau_pkg::sts_t sts,
	output rau_pkg::rsp_t rsp_data
);
	localparam int W  = rau_pkg::VALUE_WIDTH;
	localparam int WW = rau_pkg::W2;

	logic [2:0]    op_q;
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic [WW-1:0] ma_q, mb_q, d_q, m_q;
	logic [WW-1:0] x_q, y_q, rm_q, rd_q;
	logic          neg_q;
	rau_pkg::rsp_t res_q;
	rau_pkg::rsp_t res_next;

	logic          sa, sb;
	logic [W-1:0]  mag_an, mag_bn, mul_a, mul_b;
	logic [WW-1:0] prod;

	// operand signs and magnitudes
	assign sa     = an_q[W-1];
	assign sb     = bn_q[W-1];
	assign mag_an = sa ? (~an_q + 1'b1) : an_q;
	assign mag_bn = sb ? (~bn_q + 1'b1) : bn_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = ad_q;
		mul_b = bd_q;
		case (cmd.mul_sel)
			2'd0: begin
				mul_a = mag_an;
				mul_b = (op_q == rau_pkg::OP_MUL) ? mag_bn : bd_q;
			end
			2'd1: begin
				mul_a = mag_bn;
				mul_b = ad_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = (op_q == rau_pkg::OP_DIV) ? mag_bn : bd_q;
			end
		endcase
	end
	assign prod = WW'(mul_a) * WW'(mul_b);

	// signed sum of the cross products
	logic          sb_eff, neg_sum;
	logic [WW-1:0] m_sum;
	always_comb begin
		sb_eff  = ((op_q == rau_pkg::OP_SUB) ? ~sb : sb) & (mb_q != '0);
		m_sum   = ma_q;
		neg_sum = sa ^ sb;
		if (op_q == rau_pkg::OP_ADD || op_q == rau_pkg::OP_SUB) begin
			if (sa == sb_eff) begin
				m_sum   = ma_q + mb_q;
				neg_sum = sa;
			end else if (ma_q >= mb_q) begin
				m_sum   = ma_q - mb_q;
				neg_sum = sa;
			end else begin
				m_sum   = mb_q - ma_q;
				neg_sum = sb_eff;
			end
		end
	end

	// one restoring division bit per lane
	logic [WW:0] rm_n, rd_n;
	logic        qm, qd;
	assign rm_n = {rm_q, m_q[WW-1]};
	assign rd_n = {rd_q, d_q[WW-1]};
	assign qm   = rm_n >= {1'b0, x_q};
	assign qd   = rd_n >= {1'b0, x_q};

	// operand, product, GCD and divider registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= req_data.opcode;
			an_q <= req_data.a_num[W-1:0];
			ad_q <= req_data.a_den[W-1:0];
			bn_q <= req_data.b_num[W-1:0];
			bd_q <= req_data.b_den[W-1:0];
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				2'd0:    ma_q <= prod;
				2'd1:    mb_q <= prod;
				default: d_q  <= prod;
			endcase
		end
		if (cmd.sum_en) begin
			m_q   <= m_sum;
			neg_q <= neg_sum;
			x_q   <= m_sum;
			y_q   <= d_q;
			rm_q  <= '0;
			rd_q  <= '0;
		end
		if (cmd.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				m_q <= m_q >> 1;
				d_q <= d_q >> 1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q > y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end
		if (cmd.div_step) begin
			m_q  <= {m_q[WW-2:0], qm};
			d_q  <= {d_q[WW-2:0], qd};
			rm_q <= qm ? WW'(rm_n - {1'b0, x_q}) : rm_n[WW-1:0];
			rd_q <= qd ? WW'(rd_n - {1'b0, x_q}) : rd_n[WW-1:0];
		end
		if (cmd.load_res) begin
			res_q <= res_next;
		end
	end

	// exceptions and compare
	logic                zero_den, is_cmp, bad_op, div_zero, m_zero, ovf;
	logic signed [WW:0]  lhs, rhs;
	logic [WW-1:0]       lim;
	logic [W-1:0]        num_w;
	assign zero_den = (ad_q == '0) || (bd_q == '0);
	assign is_cmp   = (op_q == rau_pkg::OP_EQ) || (op_q == rau_pkg::OP_LT);
	assign bad_op   = op_q > rau_pkg::OP_LT;
	assign div_zero = (op_q == rau_pkg::OP_DIV) && (bn_q == '0);
	assign m_zero   = m_q == '0;
	assign lhs      = sa ? -$signed({1'b0, ma_q}) : $signed({1'b0, ma_q});
	assign rhs      = sb ? -$signed({1'b0, mb_q}) : $signed({1'b0, mb_q});
	assign lim      = neg_q ? (WW'(1) << (W - 1)) : ((WW'(1) << (W - 1)) - 1'b1);
	assign ovf      = (d_q[WW-1:W] != '0) || (m_q > lim);
	assign num_w    = neg_q ? (~m_q[W-1:0] + 1'b1) : m_q[W-1:0];

	assign sts.early    = zero_den || is_cmp || bad_op || div_zero || m_zero;
	assign sts.gcd_done = x_q == y_q;

	// result selection by priority; divide by zero wins over a zero numerator
	always_comb begin
		res_next.res_num      = '0;
		res_next.res_den      = rau_pkg::PORT_WIDTH'(1);
		res_next.compare_true = 1'b0;
		res_next.status       = rau_pkg::ST_OK;
		if (zero_den) begin
			res_next.status = rau_pkg::ST_ZERO_DEN;
		end else if (is_cmp) begin
			res_next.compare_true = (op_q == rau_pkg::OP_EQ) ? (lhs == rhs) : (lhs < rhs);
		end else if (bad_op) begin
			res_next.status = rau_pkg::ST_OK;
		end else if (div_zero) begin
			res_next.status = rau_pkg::ST_DIV_ZERO;
		end else if (m_zero) begin
			res_next.status = rau_pkg::ST_OK;
		end else if (ovf) begin
			res_next.status = rau_pkg::ST_OVERFLOW;
		end else begin
			res_next.res_num = rau_pkg::PORT_WIDTH'($signed(num_w));
			res_next.res_den = rau_pkg::PORT_WIDTH'(d_q[W-1:0]);
		end
	end

	assign rsp_data = res_q;
endmodule

// ===== src/rau_ctrl.sv =====
// Controller: sequences multiply, sum, GCD and divide steps and the result handshake.
`include "assert_macros.svh"
module rau_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  rau_pkg::sts_t sts,
	output rau_pkg::cmd_t cmd
);
	localparam int CW = rau_pkg::CNT_W;

	rau_pkg::state_t state_q, state_n;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || rsp_ready;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			rau_pkg::S_IDLE: if (req_valid) state_n = rau_pkg::S_MUL;
			rau_pkg::S_MUL:  if (cnt_q == CW'(2)) state_n = rau_pkg::S_SUM;
			rau_pkg::S_SUM:  state_n = rau_pkg::S_GCD;
			rau_pkg::S_GCD: begin
				if (sts.early) state_n = rau_pkg::S_FIN;
				else if (sts.gcd_done) state_n = rau_pkg::S_DIV;
			end
			rau_pkg::S_DIV:  if (cnt_q == CW'(rau_pkg::W2 - 1)) state_n = rau_pkg::S_FIN;
			rau_pkg::S_FIN:  if (slot_free) state_n = rau_pkg::S_IDLE;
			default:         state_n = rau_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		req_ready    = state_q == rau_pkg::S_IDLE;
		cmd.load_in  = req_ready && req_valid;
		cmd.mul_en   = state_q == rau_pkg::S_MUL;
		cmd.mul_sel  = cnt_q[1:0];
		cmd.sum_en   = state_q == rau_pkg::S_SUM;
		cmd.gcd_step = (state_q == rau_pkg::S_GCD) && !sts.early && !sts.gcd_done;
		cmd.div_step = state_q == rau_pkg::S_DIV;
		cmd.load_res = (state_q == rau_pkg::S_FIN) && slot_free;
	end

	// state, step counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rau_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == rau_pkg::S_MUL || state_q == rau_pkg::S_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (cmd.load_res) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

	`RAU_ASSERT(a_load_free, clk, arst_n, cmd.load_res |-> (!out_valid_q || rsp_ready), "result overwritten")
	`RAU_ASSERT(a_accept_mul, clk, arst_n, (req_valid && req_ready) |=> (state_q == rau_pkg::S_MUL), "accept did not start")
	`RAU_ASSERT(a_div_len, clk, arst_n, (cmd.div_step && cnt_q == CW'(rau_pkg::W2 - 1)) |=> (state_q == rau_pkg::S_FIN), "divide overran")
	`RAU_ASSERT_NR(a_rst_idle, clk, !arst_n |-> (state_q == rau_pkg::S_IDLE && !out_valid_q), "reset not idle")
endmodule
